### design/hmer_pkg.sv
// ----------------------------------------------------------------------------
// hmer_pkg
// types and constants shared by the emission re-estimator core and its cells
// ----------------------------------------------------------------------------
package hmer_pkg;

    localparam int NUM_SYMBOLS = 16;
    localparam int SYM_W       = 6;
    localparam int WEIGHT_W    = 17;
    localparam int EXTRA_W     = 32;
    localparam int STATE_W     = 8;
    localparam int PROB_W      = 16;
    localparam int ACC_W       = 40;
    localparam int MUL_W       = 10;
    localparam int DIV_W       = ACC_W + MUL_W;
    localparam int NUM_W       = DIV_W + 1;
    localparam int QUOT_BITS   = 17;
    localparam int QCNT_W      = 5;

    localparam logic [ACC_W-1:0]  ACC_MAX    = {ACC_W{1'b1}};
    localparam logic [MUL_W-1:0]  SCALE      = 10'd1000;
    localparam logic [MUL_W-1:0]  SMOOTH     = 10'd999;
    localparam logic [PROB_W-1:0] FLOOR_PROB = 16'd66;
    localparam logic [PROB_W-1:0] PROB_MAX   = {PROB_W{1'b1}};

    typedef struct packed {
        logic [SYM_W-1:0]    symbol;
        logic [WEIGHT_W-1:0] weight;
        logic                sequence_end;
        logic                batch_end;
        logic [EXTRA_W-1:0]  extra_denominator;
    } t_req;

    typedef struct packed {
        logic [STATE_W-1:0] row_state;
        logic [SYM_W-1:0]   symbol_index;
        logic [PROB_W-1:0]  emission_prob;
        logic               zero_mass;
        logic               last;
    } t_result;

    typedef struct packed {
        logic                acc;
        logic                shift;
        logic [SYM_W-1:0]    symbol;
        logic [WEIGHT_W-1:0] weight;
    } t_cell_ctl;

endpackage

### design/hmer_bin_cell.sv
// ----------------------------------------------------------------------------
// hmer_bin_cell
// one symbol bin: saturating accumulate on a match, shift toward cell zero
// during the emission pass
// ----------------------------------------------------------------------------
module hmer_bin_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [hmer_pkg::SYM_W-1:0]    i_index,
    input  hmer_pkg::t_cell_ctl           i_ctl,
    input  logic [hmer_pkg::ACC_W-1:0]    i_bin,
    output logic [hmer_pkg::ACC_W-1:0]    o_bin
);

    logic [hmer_pkg::ACC_W-1:0] r_bin;
    logic [hmer_pkg::ACC_W-1:0] n_bin;
    logic [hmer_pkg::ACC_W:0]   w_sum;

    assign w_sum = {1'b0, r_bin} + (hmer_pkg::ACC_W + 1)'(i_ctl.weight);

    always_comb begin
        n_bin = r_bin;
        if (i_ctl.shift) begin
            n_bin = i_bin;
        end else if (i_ctl.acc && (i_ctl.symbol == i_index)) begin
            n_bin = w_sum[hmer_pkg::ACC_W] ? hmer_pkg::ACC_MAX
                                           : w_sum[hmer_pkg::ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin <= '0;
        end else begin
            r_bin <= n_bin;
        end
    end

    assign o_bin = r_bin;

endmodule

### design/hmer_divider.sv
// ----------------------------------------------------------------------------
// hmer_divider
// restoring divider, one quotient bit per cycle, fractional quotient of a
// numerator below the divisor
// ----------------------------------------------------------------------------
module hmer_divider (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [hmer_pkg::NUM_W-1:0]        i_num,
    input  logic [hmer_pkg::DIV_W-1:0]        i_div,
    output logic                              o_done,
    output logic [hmer_pkg::QUOT_BITS-1:0]    o_quot
);

    logic                               r_run;
    logic                               r_done;
    logic [hmer_pkg::QCNT_W-1:0]        r_cnt;
    logic [hmer_pkg::NUM_W-1:0]         r_rem;
    logic [hmer_pkg::DIV_W-1:0]         r_div;
    logic [hmer_pkg::QUOT_BITS-1:0]     r_quot;
    logic [hmer_pkg::NUM_W:0]           w_trial;
    logic                               w_ge;

    assign w_trial = {r_rem, 1'b0};
    assign w_ge    = w_trial >= (hmer_pkg::NUM_W + 1)'(r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == hmer_pkg::QCNT_W'(hmer_pkg::QUOT_BITS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_div  <= i_div;
            r_quot <= '0;
        end else if (r_run) begin
            r_quot <= {r_quot[hmer_pkg::QUOT_BITS-2:0], w_ge};
            if (w_ge) begin
                r_rem <= hmer_pkg::NUM_W'(w_trial - (hmer_pkg::NUM_W + 1)'(r_div));
            end else begin
                r_rem <= w_trial[hmer_pkg::NUM_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### design/hmm_emission_reestimator_core.sv
// ----------------------------------------------------------------------------
// hmm_emission_reestimator_core
// discrete emission row re-estimation: bins accumulate posterior weights in a
// chain of cells, a batch-end request walks the chain through a serial divider
// a request without batch_end only accumulates and gives no result
// a batch-end request gives results in symbol order 0 to NUM_SYMBOLS-1, one per
// pass of the 17-step divider; busy until the last result is strobed
// throughput: one request per cycle while accumulating; results cannot stall
// reset: synchronous active low, clears bins, denominator and target_state
// ----------------------------------------------------------------------------
module hmm_emission_reestimator_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  hmer_pkg::t_req                     i_req,
    output logic                               busy,
    output logic                               o_strobe,
    output hmer_pkg::t_result                  o_result,
    input  logic                               i_cfg_we,
    input  logic [hmer_pkg::STATE_W-1:0]       i_cfg_wdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCALE = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;

    logic [2:0]                          r_state;
    logic [hmer_pkg::STATE_W-1:0]        r_target;
    logic [hmer_pkg::ACC_W-1:0]          r_den;
    logic [hmer_pkg::DIV_W-1:0]          r_div;
    logic [hmer_pkg::DIV_W-1:0]          r_prod;
    logic                                r_bin_sat;
    logic                                r_zero;
    logic [hmer_pkg::SYM_W-1:0]          r_emit_idx;
    logic                                r_strobe;
    hmer_pkg::t_result                   r_result;

    logic                                w_accept;
    logic [hmer_pkg::ACC_W+1:0]          w_den_sum;
    hmer_pkg::t_cell_ctl                 w_ctl;
    logic [hmer_pkg::ACC_W-1:0]          w_bin [hmer_pkg::NUM_SYMBOLS];
    logic                                w_div_done;
    logic [hmer_pkg::QUOT_BITS-1:0]      w_quot;
    logic [hmer_pkg::QUOT_BITS:0]        w_round;
    logic [hmer_pkg::PROB_W-1:0]         w_prob;
    logic                                w_last;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);

    assign w_ctl.acc    = w_accept;
    assign w_ctl.shift  = (r_state == S_LOAD);
    assign w_ctl.symbol = i_req.symbol;
    assign w_ctl.weight = i_req.weight;

    genvar g;
    generate
        for (g = 0; g < hmer_pkg::NUM_SYMBOLS; g++) begin : g_cell
            logic [hmer_pkg::ACC_W-1:0] w_next;
            if (g == hmer_pkg::NUM_SYMBOLS - 1) begin : g_top
                assign w_next = '0;
            end else begin : g_mid
                assign w_next = w_bin[g+1];
            end
            hmer_bin_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (hmer_pkg::SYM_W'(g)),
                .i_ctl   (w_ctl),
                .i_bin   (w_next),
                .o_bin   (w_bin[g])
            );
        end
    endgenerate

    hmer_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SUM),
        .i_num   (hmer_pkg::NUM_W'(r_prod) + hmer_pkg::NUM_W'(r_den)),
        .i_div   (r_div),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_den_sum = (hmer_pkg::ACC_W + 2)'(r_den)
                     + (i_req.sequence_end ? (hmer_pkg::ACC_W + 2)'(i_req.weight) : '0)
                     + (i_req.batch_end ? (hmer_pkg::ACC_W + 2)'(i_req.extra_denominator)
                                        : '0);

    assign w_round = ({1'b0, w_quot} + 1'b1) >> 1;
    assign w_last  = (r_emit_idx == hmer_pkg::SYM_W'(hmer_pkg::NUM_SYMBOLS - 1));

    always_comb begin
        if (r_zero) begin
            w_prob = hmer_pkg::FLOOR_PROB;
        end else if (r_bin_sat || w_round[hmer_pkg::PROB_W]) begin
            w_prob = hmer_pkg::PROB_MAX;
        end else begin
            w_prob = w_round[hmer_pkg::PROB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_target   <= '0;
            r_den      <= '0;
            r_emit_idx <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_target <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_den <= (w_den_sum[hmer_pkg::ACC_W+1:hmer_pkg::ACC_W] != 2'b00)
                               ? hmer_pkg::ACC_MAX : w_den_sum[hmer_pkg::ACC_W-1:0];
                        if (i_req.batch_end) begin
                            r_state <= S_SCALE;
                        end
                    end
                end
                S_SCALE: r_state <= S_LOAD;
                S_LOAD:  r_state <= S_SUM;
                S_SUM:   r_state <= S_DIV;
                S_DIV: begin
                    if (w_div_done) begin
                        r_strobe   <= 1'b1;
                        r_emit_idx <= w_last ? '0 : r_emit_idx + 1'b1;
                        if (w_last) begin
                            r_den   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCALE) begin
            r_div  <= hmer_pkg::DIV_W'(r_den) * hmer_pkg::DIV_W'(hmer_pkg::SCALE);
            r_zero <= (r_den == '0);
        end
        if (r_state == S_LOAD) begin
            r_prod    <= hmer_pkg::DIV_W'(w_bin[0]) * hmer_pkg::DIV_W'(hmer_pkg::SMOOTH);
            r_bin_sat <= (w_bin[0] >= r_den);
        end
        if ((r_state == S_DIV) && w_div_done) begin
            r_result.row_state     <= r_target;
            r_result.symbol_index  <= r_emit_idx;
            r_result.emission_prob <= w_prob;
            r_result.zero_mass     <= r_zero;
            r_result.last          <= w_last;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_last_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |-> !busy)
        else $error("row end result while still busy");

    a_mid_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |-> busy)
        else $error("row stopped before its last result");

    a_zero_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.zero_mass |-> o_result.emission_prob == hmer_pkg::FLOOR_PROB)
        else $error("zero mass result without floor probability");

    a_batch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req.batch_end |=> busy)
        else $error("batch end request did not start the row");

    a_first_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> r_emit_idx == '0)
        else $error("row does not start at symbol zero");

endmodule

### sim/hmm_emission_reestimator_core_tb.sv
// ----------------------------------------------------------------------------
// hmm_emission_reestimator_core_tb
// Self-checking bench for the emission row re-estimator. Requests are fed
// through the start/busy handshake while a local predictor keeps its own
// symbol bins and denominator. Every batch-end request queues the sixteen
// smoothed probabilities it should produce. Each strobed result is checked
// field by field against the oldest queued row entry. Directed requests
// cover the zero denominator, field extremes, ignored symbols, ratio
// saturation and the floor region. Randomized batches of sequences follow,
// with sender gaps and several target_state settings.
// ----------------------------------------------------------------------------
module hmm_emission_reestimator_core_tb;

    import hmer_pkg::*;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    t_req                i_req       = '0;
    logic                i_cfg_we    = 1'b0;
    logic [STATE_W-1:0]  i_cfg_wdata = '0;
    logic                busy;
    logic                o_strobe;
    t_result             o_result;

    logic [ACC_W-1:0]    bin_sum [NUM_SYMBOLS] = '{default: '0};
    logic [ACC_W-1:0]    den_sum       = '0;
    logic [STATE_W-1:0]  row_state_cfg = '0;
    t_result             row_queue [$];
    int                  mismatch_count = 0;
    int                  gap_pct        = 0;
    int                  req_count      = 0;

    hmm_emission_reestimator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [ACC_W-1:0] acc_add(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
    endfunction

    // (den + 999*bin) / (1000*den) in UQ0.16, rounded half up
    function automatic logic [PROB_W-1:0] smoothed_prob(logic [ACC_W-1:0] bin,
                                                        logic [ACC_W-1:0] den);
        logic [63:0] rem;
        logic [63:0] dvs;
        logic [17:0] q;
        rem = {24'd0, den} + {24'd0, bin} * 64'(SMOOTH);
        dvs = {24'd0, den} * 64'(SCALE);
        q   = '0;
        for (int i = 0; i < QUOT_BITS; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= dvs) begin
                rem  = rem - dvs;
                q[0] = 1'b1;
            end
        end
        q = (q + 18'd1) >> 1;
        return (q > 18'(PROB_MAX)) ? PROB_MAX : q[PROB_W-1:0];
    endfunction

    task automatic accept_req(t_req r);
        t_result res;
        if (r.symbol < NUM_SYMBOLS)
            bin_sum[r.symbol] = acc_add(bin_sum[r.symbol], ACC_W'(r.weight));
        if (r.sequence_end)
            den_sum = acc_add(den_sum, ACC_W'(r.weight));
        req_count++;
        if (r.batch_end) begin
            den_sum = acc_add(den_sum, ACC_W'(r.extra_denominator));
            for (int k = 0; k < NUM_SYMBOLS; k++) begin
                res.row_state    = row_state_cfg;
                res.symbol_index = SYM_W'(k);
                res.zero_mass    = (den_sum == '0);
                res.last         = (k == NUM_SYMBOLS - 1);
                if (den_sum == '0)
                    res.emission_prob = FLOOR_PROB;
                else if (bin_sum[k] >= den_sum)
                    res.emission_prob = PROB_MAX;
                else
                    res.emission_prob = smoothed_prob(bin_sum[k], den_sum);
                row_queue.push_back(res);
                bin_sum[k] = '0;
            end
            den_sum = '0;
        end
    endtask

    task automatic issue_req(t_req r);
        int gap;
        if ($urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        accept_req(r);
    endtask

    task automatic send(int sym, int w, bit se, bit be, logic [EXTRA_W-1:0] extra);
        t_req r;
        r.symbol            = SYM_W'(sym);
        r.weight            = WEIGHT_W'(w);
        r.sequence_end      = se;
        r.batch_end         = be;
        r.extra_denominator = extra;
        issue_req(r);
    endtask

    // lets the last row finish before anything else touches the block
    task automatic wait_for_rows();
        start <= 1'b0;
        while (row_queue.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_target_state(logic [STATE_W-1:0] v);
        i_cfg_wdata <= v;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        row_state_cfg = v;
    endtask

    task automatic test_zero_denominator();
        send(0, 0, 1'b0, 1'b1, 32'd0);
        wait_for_rows();
    endtask

    // in-range and ignored symbols, full weight, seq-end on the batch-end request
    task automatic test_field_extremes();
        send(0, 65536, 1'b0, 1'b0, 32'd0);
        send(15, 65536, 1'b0, 1'b0, 32'd0);
        send(16, 65536, 1'b1, 1'b0, 32'd0);
        send(63, 1, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send(7, 32768, 1'b1, 1'b1, 32'd0);
        wait_for_rows();
    endtask

    task automatic test_ratio_saturation();
        send(5, 65536, 1'b0, 1'b0, 32'd0);
        send(3, 65536, 1'b0, 1'b0, 32'd0);
        send(3, 65536, 1'b1, 1'b1, 32'd0);
        wait_for_rows();
    endtask

    task automatic test_floor_region();
        send(9, 1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send(10, 17'h0AAAA, 1'b0, 1'b0, 32'd0);
        send(11, 17'h05555, 1'b1, 1'b0, 32'd0);
        send(42, 65536, 1'b0, 1'b0, 32'd0);
        send(21, 17'h0FFFF, 1'b1, 1'b1, 32'h5555_AAAA);
        wait_for_rows();
        write_target_state(8'hFF);
        send(12, 1234, 1'b1, 1'b0, 32'd0);
        send(0, 0, 1'b0, 1'b1, 32'hAAAA_5555);
        wait_for_rows();
    endtask

    function automatic int rand_weight();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 65536;
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    function automatic logic [EXTRA_W-1:0] rand_extra();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return $urandom_range(0, 1 << 17);
            2:       return $urandom_range(0, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    // several sequences ending in one batch-end request; some noise mixed in
    task automatic run_random_batch();
        int   n_seq;
        int   len;
        bit   quiet;
        t_req r;
        quiet = ($urandom_range(0, 9) == 0);
        n_seq = $urandom_range(1, 4);
        for (int s = 0; s < n_seq; s++) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                r.symbol = ($urandom_range(0, 7) == 0) ? SYM_W'($urandom_range(16, 63))
                                                       : SYM_W'($urandom_range(0, 15));
                r.weight       = quiet ? '0 : WEIGHT_W'(rand_weight());
                r.sequence_end = (i == len - 1) ^ ($urandom_range(0, 19) == 0);
                r.batch_end    = (s == n_seq - 1) && (i == len - 1);
                if (r.batch_end)
                    r.extra_denominator = quiet ? '0 : rand_extra();
                else
                    r.extra_denominator = $urandom;
                issue_req(r);
            end
        end
    endtask

    task automatic test_random_phase(int pct, logic [STATE_W-1:0] cfg, int n_items);
        int first;
        write_target_state(cfg);
        gap_pct = pct;
        first   = req_count;
        while (req_count - first < n_items)
            run_random_batch();
        wait_for_rows();
    endtask

    always @(posedge i_clk) begin : check_rows
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (row_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: state %0d sym %0d prob %0d zero %b last %b",
                             o_result.row_state, o_result.symbol_index,
                             o_result.emission_prob, o_result.zero_mass, o_result.last);
            end else begin
                want = row_queue.pop_front();
                if (o_result.row_state !== want.row_state ||
                    o_result.symbol_index !== want.symbol_index ||
                    o_result.emission_prob !== want.emission_prob ||
                    o_result.zero_mass !== want.zero_mass ||
                    o_result.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp state %0d sym %0d prob %0d zero %b last %b, %s",
                                 want.row_state, want.symbol_index, want.emission_prob,
                                 want.zero_mass, want.last,
                                 $sformatf("got state %0d sym %0d prob %0d zero %b last %b",
                                           o_result.row_state, o_result.symbol_index,
                                           o_result.emission_prob, o_result.zero_mass,
                                           o_result.last));
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_denominator();
        test_field_extremes();
        test_ratio_saturation();
        test_floor_region();
        test_random_phase(30, STATE_W'($urandom_range(1, 254)), 135);
        test_random_phase(50, '0, 135);
        test_random_phase(0, 8'hFF, 135);
        if (mismatch_count == 0 && row_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
